@@ rtl/core/tgc_pkg.sv @@
// Shared types and codes for the touch gesture classifier.
package tgc_pkg;

   // Gesture codes reported on the result channel
   localparam logic [2:0] GEST_NONE  = 3'd0;
   localparam logic [2:0] GEST_TAP   = 3'd1;
   localparam logic [2:0] GEST_LONG  = 3'd2;
   localparam logic [2:0] GEST_LEFT  = 3'd3;
   localparam logic [2:0] GEST_RIGHT = 3'd4;
   localparam logic [2:0] GEST_UP    = 3'd5;
   localparam logic [2:0] GEST_DOWN  = 3'd6;

   // Item kinds carried in req_tuser
   localparam logic MODE_POLL = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_SWIPE_MIN_PX     = 2'd0;
   localparam logic [1:0] CSR_LONG_PRESS_MS    = 2'd1;
   localparam logic [1:0] CSR_BLANK_TIMEOUT_MS = 2'd2;

   // Reset values of the configuration registers
   localparam logic [9:0]  SWIPE_MIN_PX_RST     = 10'd30;
   localparam logic [15:0] LONG_PRESS_MS_RST    = 16'd600;
   localparam logic [31:0] BLANK_TIMEOUT_MS_RST = 32'd0;

   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 8;

   // One input item after unpacking
   typedef struct packed {
      logic        mode;
      logic        touch_present;
      logic [9:0]  pos_x;
      logic [9:0]  pos_y;
      logic [31:0] now_ms;
   } item_type;

   // Configuration write port
   typedef struct packed {
      logic        we;
      logic [1:0]  index;
      logic [31:0] wdata;
   } csr_type;

   // Operands of the release classifier
   typedef struct packed {
      logic [9:0]  start_x;
      logic [9:0]  start_y;
      logic [9:0]  last_x;
      logic [9:0]  last_y;
      logic [31:0] held_ms;
      logic [9:0]  swipe_min_px;
      logic [15:0] long_press_ms;
   } cls_in_type;

   // One result item
   typedef struct packed {
      logic [2:0] gesture;
      logic       blanked_out;
   } result_type;

endpackage

@@ rtl/core/tgc_classify.sv @@
// Release classifier: swipe direction, long press or tap.
module tgc_classify (
   input  tgc_pkg::cls_in_type cls_in,
   output logic [2:0]          gesture
);
   import tgc_pkg::*;

   logic       x_grow;
   logic       y_grow;
   logic [9:0] adx;
   logic [9:0] ady;
   logic       is_swipe;
   logic       is_long;

   // Absolute displacement on each axis
   assign x_grow = cls_in.last_x > cls_in.start_x;
   assign y_grow = cls_in.last_y > cls_in.start_y;
   assign adx    = x_grow ? cls_in.last_x - cls_in.start_x : cls_in.start_x - cls_in.last_x;
   assign ady    = y_grow ? cls_in.last_y - cls_in.start_y : cls_in.start_y - cls_in.last_y;

   assign is_swipe = (adx > cls_in.swipe_min_px) || (ady > cls_in.swipe_min_px);
   assign is_long  = cls_in.held_ms >= {16'd0, cls_in.long_press_ms};

   // Pick the gesture; a tie in displacement goes to the vertical axis
   always_comb begin
      if (is_swipe) begin
         if (adx > ady) begin
            gesture = x_grow ? GEST_RIGHT : GEST_LEFT;
         end else begin
            gesture = y_grow ? GEST_DOWN : GEST_UP;
         end
      end else if (is_long) begin
         gesture = GEST_LONG;
      end else begin
         gesture = GEST_TAP;
      end
   end

endmodule

@@ rtl/core/tgc_track.sv @@
// Touch tracking state, blanking timer and configuration registers.
module tgc_track (
   input  logic                clock,
   input  logic                reset,
   input  tgc_pkg::csr_type    csr,
   input  logic                fire,
   input  tgc_pkg::item_type   item,
   output tgc_pkg::result_type result
);
   import tgc_pkg::*;

   logic [9:0]  swipe_min_px_ff;
   logic [15:0] long_press_ms_ff;
   logic [31:0] blank_timeout_ms_ff;

   logic        touching_ff, touching_in;
   logic [9:0]  start_x_ff, start_x_in;
   logic [9:0]  start_y_ff, start_y_in;
   logic [9:0]  last_x_ff, last_x_in;
   logic [9:0]  last_y_ff, last_y_in;
   logic [31:0] press_time_ff, press_time_in;
   logic [31:0] activity_time_ff, activity_time_in;
   logic        blanked_ff, blanked_in;

   logic [31:0] idle_ms;
   logic        timeout_hit;
   cls_in_type  cls_in;
   logic [2:0]  cls_gesture;
   logic [2:0]  gesture;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         swipe_min_px_ff     <= SWIPE_MIN_PX_RST;
         long_press_ms_ff    <= LONG_PRESS_MS_RST;
         blank_timeout_ms_ff <= BLANK_TIMEOUT_MS_RST;
      end else if (csr.we) begin
         case (csr.index)
            CSR_SWIPE_MIN_PX:     swipe_min_px_ff     <= csr.wdata[9:0];
            CSR_LONG_PRESS_MS:    long_press_ms_ff    <= csr.wdata[15:0];
            CSR_BLANK_TIMEOUT_MS: blank_timeout_ms_ff <= csr.wdata;
            default: ;
         endcase
      end
   end

   // Classifier operands come from the stored press
   assign cls_in.start_x       = start_x_ff;
   assign cls_in.start_y       = start_y_ff;
   assign cls_in.last_x        = last_x_ff;
   assign cls_in.last_y        = last_y_ff;
   assign cls_in.held_ms       = item.now_ms - press_time_ff;
   assign cls_in.swipe_min_px  = swipe_min_px_ff;
   assign cls_in.long_press_ms = long_press_ms_ff;

   tgc_classify u_classify (
      .cls_in  (cls_in),
      .gesture (cls_gesture)
   );

   // Inactivity check for service ticks
   assign idle_ms     = item.now_ms - activity_time_ff;
   assign timeout_hit = (blank_timeout_ms_ff != 32'd0) && !blanked_ff &&
                        (idle_ms > blank_timeout_ms_ff);

   // Next state and result for the item in hand
   always_comb begin
      touching_in      = touching_ff;
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      last_x_in        = last_x_ff;
      last_y_in        = last_y_ff;
      press_time_in    = press_time_ff;
      activity_time_in = activity_time_ff;
      blanked_in       = blanked_ff;
      gesture          = GEST_NONE;
      if (item.mode == MODE_TICK) begin
         if (timeout_hit) begin
            blanked_in = 1'b1;
         end
      end else if (item.touch_present) begin
         last_x_in = item.pos_x;
         last_y_in = item.pos_y;
         if (!touching_ff) begin
            touching_in   = 1'b1;
            start_x_in    = item.pos_x;
            start_y_in    = item.pos_y;
            press_time_in = item.now_ms;
         end
         blanked_in       = 1'b0;
         activity_time_in = item.now_ms;
      end else if (touching_ff) begin
         touching_in = 1'b0;
         gesture     = cls_gesture;
      end
   end

   assign result.gesture     = gesture;
   assign result.blanked_out = blanked_in;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         touching_ff <= 1'b0;
         blanked_ff  <= 1'b0;
      end else if (fire) begin
         touching_ff <= touching_in;
         blanked_ff  <= blanked_in;
      end
   end

   // Tracked points and times
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         last_x_ff        <= '0;
         last_y_ff        <= '0;
         press_time_ff    <= '0;
         activity_time_ff <= '0;
      end else if (fire) begin
         start_x_ff       <= start_x_in;
         start_y_ff       <= start_y_in;
         last_x_ff        <= last_x_in;
         last_y_ff        <= last_y_in;
         press_time_ff    <= press_time_in;
         activity_time_ff <= activity_time_in;
      end
   end

endmodule

@@ rtl/core/touch_gesture_classifier_core.sv @@
// A req transfer reaches rsp_tvalid through the input register and then the result register.
// Throughput: one item per cycle unless rsp_tready stalls; the state update for an item
// completes in the same cycle it leaves the input register, so the next item sees it at once.
// Reset: synchronous, active high; clears valid flags and tracking state and
// loads configuration defaults (swipe 30 px, long press 600 ms, blanking off).
// Top level of the touch gesture classifier.
module touch_gesture_classifier_core (
   input  logic                             clock,
   input  logic                             reset,
   // Configuration write port
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [31:0]                      csr_wdata,
   // Input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: touch_present[0], pos_x[10:1], pos_y[20:11], now_ms[52:21], zero[55:53]
   input  logic [tgc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: mode[0]
   input  logic                             req_tuser,
   // Result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: gesture[2:0], blanked_out[3], zero[7:4]
   output logic [tgc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tgc_pkg::*;

   logic       s1_vld_ff, s1_vld_in;
   item_type   s1_item_ff;
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_res_ff;
   logic       req_xfer;
   logic       advance;
   csr_type    csr;
   result_type result;

   // Advance when the result register is free or being drained
   assign advance    = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_vld_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Capture the input transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff.mode          <= req_tuser;
         s1_item_ff.touch_present <= req_tdata[0];
         s1_item_ff.pos_x         <= req_tdata[10:1];
         s1_item_ff.pos_y         <= req_tdata[20:11];
         s1_item_ff.now_ms        <= req_tdata[52:21];
      end
   end

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   tgc_track u_track (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .fire   (advance),
      .item   (s1_item_ff),
      .result (result)
   );

   // Hold the result until the transfer
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_res_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'd0, rsp_res_ff.blanked_out, rsp_res_ff.gesture};

   // An item leaving the input register always lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("advance did not produce a result");

   // A service tick never reports a gesture
   a_tick_no_gesture: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_item_ff.mode == MODE_TICK) |=> (rsp_res_ff.gesture == GEST_NONE))
      else $error("service tick reported a gesture");

   // A poll with a touch wakes the display and reports nothing
   a_touch_wakes: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_item_ff.mode == MODE_POLL && s1_item_ff.touch_present)
      |=> (rsp_res_ff.gesture == GEST_NONE && !rsp_res_ff.blanked_out))
      else $error("touch poll reported a gesture or stayed blanked");

endmodule
